// ===== rtl/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
package spq_pkg;

   localparam int DATA_W = 32;

   // Command codes carried on the request channel
   typedef enum logic [1:0] {
      CMD_INSERT  = 2'd0,
      CMD_EXTRACT = 2'd1,
      CMD_PEEK    = 2'd2,
      CMD_CHANGE  = 2'd3
   } cmd_type;

   // Status codes returned with every response word
   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   // Per-cycle operation broadcast to every cell
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_SHIFT  = 2'd2,
      CELL_REMOVE = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type              op;
      logic signed [DATA_W-1:0] new_value;
      logic signed [DATA_W-1:0] new_priority;
   } cell_ctrl_type;

   // Sequencer states
   typedef enum logic {
      ST_IDLE     = 1'b0,
      ST_REINSERT = 1'b1
   } state_type;

endpackage

// ===== rtl/spq_cell.sv =====
// One storage cell of the queue: holds one entry and trades it with its neighbors.
module spq_cell
   import spq_pkg::*;
(
   input  logic                     clock,
   input  cell_ctrl_type            ctrl,
   input  logic                     occupied,
   input  logic                     found,
   input  logic                     left_lt,
   input  logic signed [DATA_W-1:0] left_value,
   input  logic signed [DATA_W-1:0] left_priority,
   input  logic signed [DATA_W-1:0] right_value,
   input  logic signed [DATA_W-1:0] right_priority,
   input  logic                     right_suffix,
   output logic                     lt_out,
   output logic                     suffix_out,
   output logic signed [DATA_W-1:0] value_out,
   output logic signed [DATA_W-1:0] priority_out
);

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;
   logic signed [DATA_W-1:0] priority_ff;
   logic signed [DATA_W-1:0] priority_in;
   logic                     match;

   // Compare against the incoming word: free slots sort below everything
   assign lt_out       = !occupied || (priority_ff < ctrl.new_priority);
   assign match        = occupied && (value_ff == ctrl.new_value);
   assign suffix_out   = match || right_suffix;
   assign value_out    = value_ff;
   assign priority_out = priority_ff;

   // Pick next contents: hold, take new word, or take a neighbor
   always_comb begin
      value_in    = value_ff;
      priority_in = priority_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (lt_out) begin
               if (left_lt) begin
                  value_in    = left_value;
                  priority_in = left_priority;
               end else begin
                  value_in    = ctrl.new_value;
                  priority_in = ctrl.new_priority;
               end
            end
         end
         CELL_SHIFT: begin
            value_in    = right_value;
            priority_in = right_priority;
         end
         CELL_REMOVE: begin
            if (found && !right_suffix) begin
               value_in    = right_value;
               priority_in = right_priority;
            end
         end
         default: begin
            value_in    = value_ff;
            priority_in = priority_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      priority_ff <= priority_in;
   end

endmodule

// ===== rtl/sorted_priority_queue_unit.sv =====
// Sorted priority queue built as a row of compare-and-shift cells.
//
// Usage: a request word (command, item_value, item_priority) is taken when
// req_valid is high and req_stall is low. Every command returns exactly one
// response word (result_value, status, entry_count) on the rsp_ channel,
// taken when rsp_valid is high and rsp_stall is low.
// Entries sit in cells sorted by descending priority, head cell holding the
// maximum; among equal priorities the oldest entry is nearer the head.
// Every cell compares itself with the incoming word in parallel, so insert,
// extract and peek need a single pass through the cell row: the response is
// valid the cycle after the request is taken, and one such command is taken
// per cycle while rsp_stall is low. A change-priority whose value is found
// runs a remove pass through the cell row, then an insert pass in the
// ST_REINSERT state that loads the response; no request is taken meanwhile.
// If the value is absent it responds like the other commands.
// The response sits in an output register; while rsp_stall holds it, the
// block takes no new request and the word stays unchanged.
// Reset (synchronous, active high) empties the queue and drops any pending
// response; cell contents are not cleared, only the entry count.
module sorted_priority_queue_unit
   import spq_pkg::*;
#(
   parameter int CAPACITY = 64
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_command,
   input  logic signed [DATA_W-1:0]      req_item_value,
   input  logic signed [DATA_W-1:0]      req_item_priority,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [DATA_W-1:0]      rsp_result_value,
   output logic [1:0]                    rsp_status,
   output logic [$clog2(CAPACITY+1)-1:0] rsp_entry_count
);

   localparam int               CNT_W     = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [DATA_W-1:0] pend_value_ff, pend_value_in;
   logic signed [DATA_W-1:0] pend_priority_ff, pend_priority_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]         rsp_count_ff, rsp_count_in;

   cell_ctrl_type            ctrl;
   logic                     accept;
   logic                     found;
   cmd_type                  command;

   logic [CAPACITY-1:0]      occupied;
   logic [CAPACITY-1:0]      lt;
   logic [CAPACITY-1:0]      left_lt;
   logic [CAPACITY:0]        suffix;
   logic signed [DATA_W-1:0] cell_value [CAPACITY];
   logic signed [DATA_W-1:0] cell_priority [CAPACITY];
   logic signed [DATA_W-1:0] left_value [CAPACITY];
   logic signed [DATA_W-1:0] left_priority [CAPACITY];
   logic signed [DATA_W-1:0] right_value [CAPACITY];
   logic signed [DATA_W-1:0] right_priority [CAPACITY];

   // Build the cell row and its neighbor links
   assign suffix[CAPACITY] = 1'b0;
   assign found            = suffix[0];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign occupied[i] = CNT_W'(i) < count_ff;

      if (i == 0) begin : g_head
         assign left_lt[i]       = 1'b0;
         assign left_value[i]    = ctrl.new_value;
         assign left_priority[i] = ctrl.new_priority;
      end else begin : g_mid
         assign left_lt[i]       = lt[i-1];
         assign left_value[i]    = cell_value[i-1];
         assign left_priority[i] = cell_priority[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_value[i]    = ctrl.new_value;
         assign right_priority[i] = ctrl.new_priority;
      end else begin : g_body
         assign right_value[i]    = cell_value[i+1];
         assign right_priority[i] = cell_priority[i+1];
      end

      spq_cell u_cell (
         .clock          (clock),
         .ctrl           (ctrl),
         .occupied       (occupied[i]),
         .found          (found),
         .left_lt        (left_lt[i]),
         .left_value     (left_value[i]),
         .left_priority  (left_priority[i]),
         .right_value    (right_value[i]),
         .right_priority (right_priority[i]),
         .right_suffix   (suffix[i+1]),
         .lt_out         (lt[i]),
         .suffix_out     (suffix[i]),
         .value_out      (cell_value[i]),
         .priority_out   (cell_priority[i])
      );
   end

   // Take a request only when idle and the response slot frees up
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign command   = cmd_type'(req_command);

   // Sequence commands, drive the cell row and load the response word
   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      pend_value_in    = pend_value_ff;
      pend_priority_in = pend_priority_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_value_in     = rsp_value_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_count_in     = rsp_count_ff;
      ctrl.op           = CELL_HOLD;
      ctrl.new_value    = req_item_value;
      ctrl.new_priority = req_item_priority;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = STAT_OK;
               case (command)
                  CMD_INSERT: begin
                     if (count_ff == CAP_COUNT) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        ctrl.op  = CELL_INSERT;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_EXTRACT: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        rsp_value_in = cell_value[0];
                        ctrl.op      = CELL_SHIFT;
                        count_in     = count_ff - 1'b1;
                     end
                  end
                  CMD_PEEK: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        rsp_value_in = cell_value[0];
                     end
                  end
                  CMD_CHANGE: begin
                     if (!found) begin
                        rsp_status_in = STAT_NOT_FOUND;
                     end else begin
                        rsp_valid_in     = 1'b0;
                        ctrl.op          = CELL_REMOVE;
                        count_in         = count_ff - 1'b1;
                        pend_value_in    = req_item_value;
                        pend_priority_in = req_item_priority;
                        state_in         = ST_REINSERT;
                     end
                  end
                  default: begin
                     rsp_status_in = STAT_OK;
                  end
               endcase
               rsp_count_in = count_in;
            end
         end
         ST_REINSERT: begin
            ctrl.op           = CELL_INSERT;
            ctrl.new_value    = pend_value_ff;
            ctrl.new_priority = pend_priority_ff;
            count_in          = count_ff + 1'b1;
            rsp_valid_in      = 1'b1;
            rsp_value_in      = '0;
            rsp_status_in     = STAT_OK;
            rsp_count_in      = count_in;
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_value_ff    <= pend_value_in;
      pend_priority_ff <= pend_priority_in;
      rsp_value_ff     <= rsp_value_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_count_ff     <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_count  = rsp_count_ff;

   // Count never passes the number of cells
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_COUNT)
      else $error("entry count above capacity");

   // A pending response always reports the live count
   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff == count_ff))
      else $error("response count differs from stored count");

   // Reinsert pass runs with the response slot empty, and the state is back to idle in the next cycle
   a_reinsert_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REINSERT) |-> !rsp_valid_ff)
      else $error("response pending during reinsert");

   a_reinsert_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REINSERT) |=> (state_ff == ST_IDLE))
      else $error("reinsert lasted more than one cycle");

   // A full-queue drop is only reported at capacity
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STAT_FULL)) |-> (count_ff == CAP_COUNT))
      else $error("full status below capacity");

endmodule
